>>> hdl/arpc_pkg.sv
`default_nettype none
package arpc_pkg;

  localparam int RELAY_NUM = 16;
  localparam int IDX_W = (RELAY_NUM > 1) ? $clog2(RELAY_NUM) : 1;
  localparam int DRIVE_W = 16;
  localparam int TICK_W = 16;
  localparam int VALUE_W = 32;

  localparam logic [TICK_W-1:0] CLOSE_PERIOD_RESET = 16'd700;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // opcodes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_PING      = 3'd1;
  localparam logic [2:0] OP_GET_ARMED = 3'd2;
  localparam logic [2:0] OP_SET_ARMED = 3'd3;
  localparam logic [2:0] OP_IGNITE    = 3'd4;

  // reply kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PING    = 2'd1;
  localparam logic [1:0] KIND_ARMED   = 2'd2;
  localparam logic [1:0] KIND_CONFIRM = 2'd3;

  // back-end actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_FIRE = 2'd2;

  // configuration register index
  localparam logic REG_CLOSE_PERIOD = 1'b0;

  typedef struct packed {
    logic [1:0]         act;
    logic [1:0]         kind;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   idx;
  } cmd_t;

endpackage
`default_nettype wire

>>> hdl/arpc_front.sv
`default_nettype none
module arpc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_opcode,
  input  wire logic [31:0]        in_ping_iteration,
  input  wire logic               in_arm_value,
  input  wire logic [7:0]         in_relay_index,
  input  wire logic               q_full,
  output logic                    q_push,
  output arpc_pkg::cmd_t          q_entry
);

  logic armed_r;
  logic armed_nxt;
  logic idx_ok;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign idx_ok   = in_relay_index < 8'(arpc_pkg::RELAY_NUM);

  always_comb begin
    q_entry       = '0;
    q_entry.idx   = in_relay_index[arpc_pkg::IDX_W-1:0];
    armed_nxt     = armed_r;
    unique case (in_opcode)
      arpc_pkg::OP_TICK: begin
        q_entry.act = arpc_pkg::ACT_TICK;
      end
      arpc_pkg::OP_PING: begin
        q_entry.kind  = arpc_pkg::KIND_PING;
        q_entry.value = in_ping_iteration;
      end
      arpc_pkg::OP_GET_ARMED: begin
        q_entry.kind  = arpc_pkg::KIND_ARMED;
        q_entry.value = arpc_pkg::VALUE_W'(armed_r);
      end
      arpc_pkg::OP_SET_ARMED: begin
        armed_nxt = in_arm_value;
      end
      arpc_pkg::OP_IGNITE: begin
        if (armed_r) begin
          q_entry.act   = idx_ok ? arpc_pkg::ACT_FIRE : arpc_pkg::ACT_NONE;
          q_entry.kind  = arpc_pkg::KIND_CONFIRM;
          q_entry.value = arpc_pkg::VALUE_W'(in_relay_index);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else if (q_push) begin
      armed_r <= armed_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/arpc_queue.sv
`default_nettype none
module arpc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  arpc_pkg::cmd_t      push_entry,
  output logic                full,
  output logic                head_valid,
  output arpc_pkg::cmd_t      head_entry,
  input  wire logic           pop
);

  arpc_pkg::cmd_t                 slot_r [arpc_pkg::QDEPTH];
  logic [arpc_pkg::QPTR_W-1:0]    wptr_r;
  logic [arpc_pkg::QPTR_W-1:0]    rptr_r;
  logic [arpc_pkg::QPTR_W:0]      count_r;

  assign full       = count_r == (arpc_pkg::QPTR_W+1)'(arpc_pkg::QDEPTH);
  assign head_valid = count_r != '0;
  assign head_entry = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/arpc_back.sv
`default_nettype none
module arpc_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [arpc_pkg::TICK_W-1:0]  close_period,
  input  wire logic                         q_valid,
  input  arpc_pkg::cmd_t                    q_entry,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_reply_kind,
  output logic [31:0]                       out_reply_value,
  output logic [15:0]                       out_relay_drive
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [arpc_pkg::IDX_W-1:0] LAST_IDX = arpc_pkg::IDX_W'(arpc_pkg::RELAY_NUM - 1);

  logic [1:0]                      state_r, state_nxt;
  logic [arpc_pkg::IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [arpc_pkg::RELAY_NUM-1:0]  closed_r, closed_nxt;
  logic [arpc_pkg::TICK_W-1:0]     ticks_r [arpc_pkg::RELAY_NUM];

  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      kind_r, kind_nxt;
  logic [31:0]                     value_r, value_nxt;
  logic [15:0]                     drive_r, drive_nxt;

  logic                            wr_en;
  logic [arpc_pkg::IDX_W-1:0]      wr_addr;
  logic [arpc_pkg::TICK_W-1:0]     wr_data;
  logic [arpc_pkg::TICK_W-1:0]     rd_data;
  logic [arpc_pkg::TICK_W-1:0]     dec;
  logic [arpc_pkg::RELAY_NUM-1:0]  fire_vec;
  logic                            out_free;

  assign out_free        = !out_valid_r || out_ready;
  assign rd_data         = ticks_r[cnt_r];
  assign dec             = (rd_data != '0) ? rd_data - 1'b1 : rd_data;
  assign out_valid       = out_valid_r;
  assign out_reply_kind  = kind_r;
  assign out_reply_value = value_r;
  assign out_relay_drive = drive_r;

  always_comb begin
    for (int i = 0; i < arpc_pkg::RELAY_NUM; i++) begin
      fire_vec[i] = (q_entry.idx == arpc_pkg::IDX_W'(i));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    closed_nxt    = closed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    drive_nxt     = drive_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r;
    wr_data       = dec;
    q_pop         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_entry.act == arpc_pkg::ACT_TICK) begin
            state_nxt = ST_SCAN;
            cnt_nxt   = '0;
          end else if (out_free) begin
            if (q_entry.act == arpc_pkg::ACT_FIRE) begin
              closed_nxt = closed_r | fire_vec;
              wr_en      = 1'b1;
              wr_addr    = q_entry.idx;
              wr_data    = close_period;
            end
            q_pop         = 1'b1;
            out_valid_nxt = 1'b1;
            kind_nxt      = q_entry.kind;
            value_nxt     = q_entry.value;
            drive_nxt     = 16'(closed_nxt);
          end
        end
      end
      ST_SCAN: begin
        if (closed_r[cnt_r]) begin
          wr_en = 1'b1;
          if (dec == '0) begin
            closed_nxt[cnt_r] = 1'b0;
          end
        end
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          kind_nxt      = q_entry.kind;
          value_nxt     = q_entry.value;
          drive_nxt     = 16'(closed_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ticks_r[wr_addr] <= wr_data;
    end
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    drive_r <= drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      closed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/armed_relay_pulse_controller_core.sv
`default_nettype none
// channel   | ports                                           | handshake
// ----------+-------------------------------------------------+-----------------
// input     | in_opcode, in_ping_iteration, in_arm_value,     | in_valid/in_ready
//           | in_relay_index                                  |
// result    | out_reply_kind, out_reply_value, out_relay_drive| out_valid/out_ready
// config    | cfg_psel/penable/pwrite/paddr/pwdata/prdata     | apb, pready high
//
// a tick walks the back end from IDLE through SCAN to FIN, where it waits for the result register: the
//   down-counters sit behind one read and one write port and are visited one a cycle
// every other command leaves the back end straight from IDLE once the result register is free
// the front end takes one transfer a cycle while the two-entry command queue has room
// rst_n is synchronous: it disarms, opens all relays, empties the queue, period = 700
// a stalled result holds in the output register; the queue absorbs up to two more items
module armed_relay_pulse_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [31:0] in_ping_iteration,
  input  wire logic        in_arm_value,
  input  wire logic [7:0]  in_relay_index,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_reply_kind,
  output logic [31:0]      out_reply_value,
  output logic [15:0]      out_relay_drive,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [arpc_pkg::TICK_W-1:0] close_period_r;
  logic                        cfg_wr;
  logic                        cfg_sel_period;

  // queue hookup
  logic                        q_push;
  logic                        q_full;
  logic                        q_valid;
  logic                        q_pop;
  arpc_pkg::cmd_t              q_in_entry;
  arpc_pkg::cmd_t              q_head;

  // register file: one register, word index taken from paddr[2]
  assign cfg_pready     = 1'b1;
  assign cfg_sel_period = cfg_paddr[2] == arpc_pkg::REG_CLOSE_PERIOD;
  assign cfg_wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata     = cfg_sel_period ? 32'(close_period_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_period_r <= arpc_pkg::CLOSE_PERIOD_RESET;
    end else if (cfg_wr && cfg_sel_period) begin
      close_period_r <= cfg_pwdata[arpc_pkg::TICK_W-1:0];
    end
  end

  // front: decode, arm interlock, reply precompute
  arpc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_ping_iteration (in_ping_iteration),
    .in_arm_value      (in_arm_value),
    .in_relay_index    (in_relay_index),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (q_in_entry)
  );

  // decoupling queue
  arpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in_entry),
    .full       (q_full),
    .head_valid (q_valid),
    .head_entry (q_head),
    .pop        (q_pop)
  );

  // back: relay state, tick scan, result register
  arpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .close_period    (close_period_r),
    .q_valid         (q_valid),
    .q_entry         (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reply_kind  (out_reply_kind),
    .out_reply_value (out_reply_value),
    .out_relay_drive (out_relay_drive)
  );

endmodule
`default_nettype wire

>>> test/relay_reply_checker.sv
`timescale 1ns / 100ps
module relay_reply_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_ready,
  input  wire logic [2:0]   in_opcode,
  input  wire logic [31:0]  in_ping_iteration,
  input  wire logic         in_arm_value,
  input  wire logic [7:0]   in_relay_index,
  input  wire logic         out_valid,
  input  wire logic         out_ready,
  input  wire logic [1:0]   out_reply_kind,
  input  wire logic [31:0]  out_reply_value,
  input  wire logic [15:0]  out_relay_drive,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  input  wire logic         cfg_pready,
  output int                error_count,
  output int                replies_due,
  output int                replies_checked
);

  typedef struct packed {
    logic [1:0]                   kind;
    logic [arpc_pkg::VALUE_W-1:0] value;
    logic [arpc_pkg::DRIVE_W-1:0] drive;
  } relay_reply_t;

  relay_reply_t pending_replies[$];

  logic [arpc_pkg::TICK_W-1:0]    period_q;
  logic                           armed_q;
  logic [arpc_pkg::RELAY_NUM-1:0] closed_q;
  logic [arpc_pkg::TICK_W-1:0]    ticks_left [arpc_pkg::RELAY_NUM];
  int                             errs;
  int                             checked;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      errs++;
    end
  endtask

  // one command against the shadow state, giving the result it must produce
  task automatic apply_command(input logic [2:0] op, input logic [31:0] iter,
                               input logic arm, input logic [7:0] idx,
                               output relay_reply_t r);
    r = '0;
    case (op)
      arpc_pkg::OP_TICK: begin
        for (int i = 0; i < arpc_pkg::RELAY_NUM; i++) begin
          if (closed_q[i]) begin
            if (ticks_left[i] != '0) ticks_left[i] = ticks_left[i] - 1'b1;
            if (ticks_left[i] == '0) closed_q[i] = 1'b0;
          end
        end
      end
      arpc_pkg::OP_PING: begin
        r.kind  = arpc_pkg::KIND_PING;
        r.value = iter;
      end
      arpc_pkg::OP_GET_ARMED: begin
        r.kind  = arpc_pkg::KIND_ARMED;
        r.value = arpc_pkg::VALUE_W'(armed_q);
      end
      arpc_pkg::OP_SET_ARMED: armed_q = arm;
      arpc_pkg::OP_IGNITE: begin
        if (armed_q) begin
          if (idx < arpc_pkg::RELAY_NUM) begin
            closed_q[idx]   = 1'b1;
            ticks_left[idx] = period_q;
          end
          r.kind  = arpc_pkg::KIND_CONFIRM;
          r.value = arpc_pkg::VALUE_W'(idx);
        end
      end
      default: ;
    endcase
    r.drive = arpc_pkg::DRIVE_W'(closed_q);
  endtask

  always @(posedge clk) begin
    relay_reply_t want;
    relay_reply_t got;
    if (!rst_n) begin
      period_q = arpc_pkg::CLOSE_PERIOD_RESET;
      armed_q  = 1'b0;
      closed_q = '0;
      for (int i = 0; i < arpc_pkg::RELAY_NUM; i++) ticks_left[i] = '0;
      pending_replies.delete();
      errs    = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind  = out_reply_kind;
        got.value = out_reply_value;
        got.drive = out_relay_drive;
        if (pending_replies.size() == 0) begin
          $display("%0t result with nothing expected: kind %0h value %0h drive %0h",
                   $time, got.kind, got.value, got.drive);
          errs++;
        end else begin
          want = pending_replies.pop_front();
          check_field("reply_kind", 32'(want.kind), 32'(got.kind));
          check_field("reply_value", want.value, got.value);
          check_field("relay_drive", 32'(want.drive), 32'(got.drive));
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        apply_command(in_opcode, in_ping_iteration, in_arm_value, in_relay_index, want);
        pending_replies.push_back(want);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {arpc_pkg::REG_CLOSE_PERIOD, 2'b00})
        period_q = cfg_pwdata[arpc_pkg::TICK_W-1:0];
    end
    error_count     <= errs;
    replies_due     <= pending_replies.size();
    replies_checked <= checked;
  end

endmodule

>>> test/tb_armed_relay_pulse_controller_core.sv
`timescale 1ns / 100ps
module tb_armed_relay_pulse_controller_core;

  // first of the opcodes the block ignores (five, six and seven)
  localparam logic [2:0] OP_UNKNOWN = 3'd5;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS    = 400;
  localparam int PHASES          = 8;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int BURST_ITEMS     = 12;
  localparam int SETTLE_CYCLES   = 40;
  // longest quiet stretch: sender gap + hold-off + receiver stall + tick scan, many times over
  localparam int WATCHDOG_LIMIT  = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [31:0] in_ping_iteration;
  logic        in_arm_value;
  logic [7:0]  in_relay_index;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_reply_kind;
  logic [31:0] out_reply_value;
  logic [15:0] out_relay_drive;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int error_count;
  int replies_due;
  int replies_checked;

  // idling controls shared by the sender and the receiver
  bit   calm;          // no gaps and no stalls on either side
  bit   burst;         // sender offers back to back
  int   hold_asks;     // hold-off requests from the stimulus
  int   hold_done;     // hold-offs served by the receiver
  int   sent_total;
  int   period_writes;
  logic armed_shadow;  // arm state as the stimulus last set it

  logic [arpc_pkg::TICK_W-1:0] period_plan [PHASES] = '{16'd1, 16'd0, 16'd3, 16'hFFFF,
                                                        16'd5, 16'd2,
                                                        arpc_pkg::CLOSE_PERIOD_RESET, 16'd9};

  armed_relay_pulse_controller_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_ping_iteration (in_ping_iteration),
    .in_arm_value      (in_arm_value),
    .in_relay_index    (in_relay_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reply_kind    (out_reply_kind),
    .out_reply_value   (out_reply_value),
    .out_relay_drive   (out_relay_drive),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  // watches both channels and the register port, predicts and compares
  relay_reply_checker i_relay_reply_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_ping_iteration (in_ping_iteration),
    .in_arm_value      (in_arm_value),
    .in_relay_index    (in_relay_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reply_kind    (out_reply_kind),
    .out_reply_value   (out_reply_value),
    .out_relay_drive   (out_relay_drive),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_pready        (cfg_pready),
    .error_count       (error_count),
    .replies_due       (replies_due),
    .replies_checked   (replies_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short waits, now and then a long one
  function automatic int pick_wait(input int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // one transfer on the input channel; returns at the edge that accepted it
  task automatic send_item(input logic [2:0] op, input logic [31:0] iter,
                           input logic arm, input logic [7:0] idx);
    int gap;
    gap = (calm || burst) ? 0 : pick_wait(60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_ping_iteration <= iter;
    in_arm_value      <= arm;
    in_relay_index    <= idx;
    do @(posedge clk); while (!in_ready);
    if (op == arpc_pkg::OP_SET_ARMED) armed_shadow = arm;
    sent_total++;
  endtask

  // weighted command mix: lots of ticks and ignites so relays close and reopen
  task automatic send_random_command(output bit counts);
    logic [2:0]  op;
    logic [31:0] iter;
    logic        arm;
    logic [7:0]  idx;
    int          r;
    r    = $urandom_range(0, 99);
    iter = $urandom;
    arm  = $urandom_range(0, 1);
    idx  = $urandom_range(0, 255);
    if (r < 35) begin
      op = arpc_pkg::OP_TICK;
    end else if (r < 64) begin
      op = arpc_pkg::OP_IGNITE;
      // mostly real relays, sometimes an index past the last one
      if ($urandom_range(0, 9) != 0) idx = $urandom_range(0, arpc_pkg::RELAY_NUM - 1);
    end else if (r < 74) begin
      op = arpc_pkg::OP_PING;
    end else if (r < 82) begin
      op = arpc_pkg::OP_GET_ARMED;
    end else if (r < 90) begin
      op  = arpc_pkg::OP_SET_ARMED;
      arm = ($urandom_range(0, 4) != 0);
    end else begin
      op = OP_UNKNOWN + 3'($urandom_range(0, 2));
    end
    // ignored items do not count toward the random quota
    counts = !(op >= OP_UNKNOWN || (op == arpc_pkg::OP_IGNITE && !armed_shadow));
    send_item(op, iter, arm, idx);
  endtask

  // drop valid and wait until every expected result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
  endtask

  // apb write of the close period: setup then access
  task automatic write_period(input logic [arpc_pkg::TICK_W-1:0] p);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {arpc_pkg::REG_CLOSE_PERIOD, 2'b00};
    cfg_pwdata  <= {16'($urandom), p};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    period_writes++;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_asks) begin
        // counted here so the sender keeps pushing while results back up
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done++;
        out_ready <= 1'b1;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (pick_wait(0)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
             WATCHDOG_LIMIT, replies_due);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int  counted;
    bit  counts;
    // every input known from time zero, reset held from the start
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_opcode         = arpc_pkg::OP_TICK;
    in_ping_iteration = '0;
    in_arm_value      = 1'b0;
    in_relay_index    = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    calm              = 1'b0;
    burst             = 1'b0;
    hold_asks         = 0;
    hold_done         = 0;
    sent_total        = 0;
    period_writes     = 0;
    armed_shadow      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset period of 700
    send_item(arpc_pkg::OP_GET_ARMED, 32'h0, 1'b1, 8'hFF);   // disarmed after reset
    send_item(arpc_pkg::OP_IGNITE, 32'h0, 1'b0, 8'd3);       // ignite while disarmed: ignored
    send_item(arpc_pkg::OP_PING, 32'h0000_0000, 1'b0, 8'd0);
    send_item(arpc_pkg::OP_PING, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    send_item(OP_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 8'd1);        // unknown opcodes do nothing
    send_item(OP_SPARE_A, 32'h5A5A_5A5A, 1'b1, 8'd2);
    send_item(OP_SPARE_B, 32'hA5A5_A5A5, 1'b0, 8'd4);
    send_item(arpc_pkg::OP_SET_ARMED, 32'hFFFF_FFFF, 1'b1, 8'hFF); // set armed: the result is of kind none
    send_item(arpc_pkg::OP_GET_ARMED, 32'h0, 1'b0, 8'd0);
    send_item(arpc_pkg::OP_IGNITE, 32'h0, 1'b0, 8'd0);       // lowest relay
    send_item(arpc_pkg::OP_IGNITE, 32'h0, 1'b0, 8'(arpc_pkg::RELAY_NUM - 1)); // highest relay
    send_item(arpc_pkg::OP_IGNITE, 32'h0, 1'b0, 8'(arpc_pkg::RELAY_NUM)); // first past the end
    send_item(arpc_pkg::OP_IGNITE, 32'h0, 1'b0, 8'hFF);      // largest index
    send_item(arpc_pkg::OP_TICK, 32'h0, 1'b0, 8'd0);
    send_item(arpc_pkg::OP_IGNITE, 32'h0, 1'b0, 8'd0);       // already closed: reload
    send_item(arpc_pkg::OP_SET_ARMED, 32'h0, 1'b0, 8'd0);
    send_item(arpc_pkg::OP_GET_ARMED, 32'h0, 1'b0, 8'd0);
    send_item(arpc_pkg::OP_IGNITE, 32'h0, 1'b0, 8'd5);       // disarmed again
    send_item(arpc_pkg::OP_SET_ARMED, 32'h0, 1'b1, 8'd0);
    wait_drained();

    // a period of one opens at the first tick after ignition
    write_period(16'd1);
    send_item(arpc_pkg::OP_IGNITE, 32'h0, 1'b0, 8'd7);
    send_item(arpc_pkg::OP_TICK, 32'h0, 1'b0, 8'd0);
    wait_drained();

    // a period of zero behaves the same
    write_period(16'd0);
    send_item(arpc_pkg::OP_IGNITE, 32'h0, 1'b0, 8'd9);
    send_item(arpc_pkg::OP_TICK, 32'h0, 1'b0, 8'd0);
    send_item(arpc_pkg::OP_TICK, 32'h0, 1'b0, 8'd0);

    // random phases, each under its own close period, drained before the write
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_period(period_plan[ph]);
      calm = (ph == 2);
      send_item(arpc_pkg::OP_SET_ARMED, $urandom, 1'b1, 8'($urandom));
      if (ph == 4) begin
        // receiver holds off while the sender keeps offering, so the queue fills
        hold_asks++;
        burst = 1'b1;
        repeat (BURST_ITEMS) send_random_command(counts);
        burst = 1'b0;
      end
      counted = 0;
      while (counted < RANDOM_ITEMS / PHASES) begin
        send_random_command(counts);
        if (counts) counted++;
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d commands under %0d close-period settings, %0d results compared",
             sent_total, period_writes + 1, replies_checked);
    $display("including arm interlock, out-of-range ignites, reloads and a full-queue hold-off");
    if (error_count == 0 && replies_due == 0) begin
      $display("tb: success");
    end else begin
      $display("errors: %0d, results never delivered: %0d", error_count, replies_due);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
